FILE: rtl/csvt_pkg.sv
// Shared types and constants for the CSV record tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_RECORD = 1'b1;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_QUOTE_UNQ    = 3'd1;
  localparam logic [2:0] ERR_BAD_AFTER_Q  = 3'd2;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd3;
  localparam logic [2:0] ERR_EXTRA_RECORD = 3'd4;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic       has_content;
    logic [7:0] content_byte;
    logic       field_end;
    logic       record_end;
    logic [2:0] error_code;
    logic       text_done;
  } result_t;

  // pair: a closing record mark follows the first result
  typedef struct packed {
    result_t first;
    logic    pair;
  } entry_t;

  localparam result_t RESULT_ZERO  = '0;
  localparam result_t RESULT_CLOSE = '{has_content: 1'b0, content_byte: 8'd0,
                                       field_end: 1'b1, record_end: 1'b1,
                                       error_code: ERR_NONE, text_done: 1'b1};

endpackage

FILE: rtl/csvt_front.sv
// Front end: configuration registers, byte classification and parse state.
`timescale 1ns / 1ps

module csvt_front
  import csvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_accept,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_final_byte,
  output logic                  push,
  output entry_t                push_entry
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_UNQ     = 3'd1,
    PH_QUO     = 3'd2,
    PH_QSEEN   = 3'd3,
    PH_AFTCR   = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_w;
  logic       record_seen_r, record_seen_nxt;
  logic [7:0] delimiter_r, delimiter_nxt;
  logic       single_record_r, single_record_nxt;
  logic [7:0] delim_eff;
  logic       term;
  logic       fin;
  logic [7:0] b;

  always_comb begin
    delimiter_nxt     = delimiter_r;
    single_record_nxt = single_record_r;
    if (cfg_write_en) begin
      case (cfg_index)
        REG_DELIMITER:     delimiter_nxt     = cfg_data[7:0];
        REG_SINGLE_RECORD: single_record_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  assign b   = in_text_byte;
  assign fin = in_final_byte;
  assign delim_eff = (delimiter_r == CH_NUL || delimiter_r == CH_QUOTE ||
                      delimiter_r == CH_CR || delimiter_r == CH_LF) ? CH_COMMA : delimiter_r;
  assign term = (b == delim_eff) || (b == CH_CR) || (b == CH_LF);

  always_comb begin
    phase_nxt       = phase_r;
    record_seen_nxt = record_seen_r;
    push            = 1'b0;
    push_entry      = '0;
    phase_w         = phase_r;

    if (phase_r == PH_AFTCR && b == CH_LF) begin
      phase_nxt = PH_START;
      if (fin) begin
        push                       = 1'b1;
        push_entry.first.text_done = 1'b1;
      end
    end else begin
      if (phase_r == PH_AFTCR || phase_r > PH_DISCARD) begin
        phase_w = PH_START;
      end
      if (phase_w == PH_START && single_record_r && record_seen_r) begin
        push                        = 1'b1;
        push_entry.first.error_code = ERR_EXTRA_RECORD;
        push_entry.first.text_done  = fin;
        phase_nxt                   = PH_DISCARD;
      end else begin
        unique case (phase_w)
          PH_START, PH_UNQ: begin
            if (term) begin
              push = 1'b1;
              push_entry.first.field_end = 1'b1;
              if (b == delim_eff) begin
                push_entry.pair = fin;
                phase_nxt       = PH_START;
              end else begin
                push_entry.first.record_end = 1'b1;
                push_entry.first.text_done  = fin;
                record_seen_nxt             = 1'b1;
                phase_nxt = (b == CH_CR) ? PH_AFTCR : PH_START;
              end
            end else if (b == CH_QUOTE) begin
              if (phase_w == PH_UNQ || fin) begin
                push = 1'b1;
                push_entry.first.error_code =
                  (phase_w == PH_UNQ) ? ERR_QUOTE_UNQ : ERR_UNTERMINATED;
                push_entry.first.text_done = fin;
                phase_nxt = PH_DISCARD;
              end else begin
                phase_nxt = PH_QUO;
              end
            end else begin
              push = 1'b1;
              push_entry.first.has_content  = 1'b1;
              push_entry.first.content_byte = b;
              push_entry.first.field_end    = fin;
              push_entry.first.record_end   = fin;
              push_entry.first.text_done    = fin;
              phase_nxt = PH_UNQ;
            end
          end
          PH_QUO: begin
            if (b == CH_QUOTE) begin
              if (fin) begin
                push             = 1'b1;
                push_entry.first = RESULT_CLOSE;
              end else begin
                phase_nxt = PH_QSEEN;
              end
            end else if (fin) begin
              push = 1'b1;
              push_entry.first.error_code = ERR_UNTERMINATED;
              push_entry.first.text_done  = 1'b1;
              phase_nxt = PH_DISCARD;
            end else begin
              push = 1'b1;
              push_entry.first.has_content  = 1'b1;
              push_entry.first.content_byte = b;
            end
          end
          PH_QSEEN: begin
            if (b == CH_QUOTE) begin
              push = 1'b1;
              if (fin) begin
                push_entry.first.error_code = ERR_UNTERMINATED;
                push_entry.first.text_done  = 1'b1;
                phase_nxt = PH_DISCARD;
              end else begin
                push_entry.first.has_content  = 1'b1;
                push_entry.first.content_byte = b;
                phase_nxt = PH_QUO;
              end
            end else if (term) begin
              push = 1'b1;
              push_entry.first.field_end = 1'b1;
              if (b == delim_eff) begin
                push_entry.pair = fin;
                phase_nxt       = PH_START;
              end else begin
                push_entry.first.record_end = 1'b1;
                push_entry.first.text_done  = fin;
                record_seen_nxt             = 1'b1;
                phase_nxt = (b == CH_CR) ? PH_AFTCR : PH_START;
              end
            end else begin
              push = 1'b1;
              push_entry.first.error_code = ERR_BAD_AFTER_Q;
              push_entry.first.text_done  = fin;
              phase_nxt = PH_DISCARD;
            end
          end
          default: begin
            if (fin) begin
              push                       = 1'b1;
              push_entry.first.text_done = 1'b1;
            end
          end
        endcase
      end
    end

    if (fin) begin
      phase_nxt       = PH_START;
      record_seen_nxt = 1'b0;
    end
    if (!in_accept) begin
      push            = 1'b0;
      phase_nxt       = phase_r;
      record_seen_nxt = record_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      record_seen_r   <= 1'b0;
      delimiter_r     <= CH_COMMA;
      single_record_r <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      record_seen_r   <= record_seen_nxt;
      delimiter_r     <= delimiter_nxt;
      single_record_r <= single_record_nxt;
    end
  end

endmodule

FILE: rtl/csvt_queue.sv
// Short queue of classified entries between the front and back ends.
`timescale 1ns / 1ps

module csvt_queue
  import csvt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/csvt_back.sv
// Back end: expands queue entries into results and holds the output register.
`timescale 1ns / 1ps

module csvt_back
  import csvt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  entry_t  head,
  input  logic    empty,
  output logic    pop,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_result
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_result_r, out_result_nxt;
  logic    half_r, half_nxt;
  logic    load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !empty && (!head.pair || half_r);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    half_nxt       = half_r;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        if (half_r) begin
          out_result_nxt = RESULT_CLOSE;
          half_nxt       = 1'b0;
        end else begin
          out_result_nxt = head.first;
          half_nxt       = head.pair;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: rtl/csv_record_tokenizer_top.sv
// Top level of the CSV record tokenizer.
//
// Input channel: in_valid/in_stall carry one byte of CSV text (in_text_byte)
// and a flag on the last byte of the text (in_final_byte). A transaction is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry one result per transaction:
// a content byte, field and record marks, an error code and text_done.
// One input byte yields zero, one or two results; each result passes through
// the queue and then the output register. The input takes one byte per cycle
// while in_stall is low; a delimiter on the final byte yields two results,
// which leave the output register one after the other.
// The front parses each byte combinationally and writes results into a queue
// of QUEUE_DEPTH entries; in_stall rises only when that queue is full,
// which happens when the receiver holds out_stall or when two-result bytes
// arrive faster than the output register drains them.
// Configuration: cfg_write_en writes cfg_data into register cfg_index
// (0 delimiter, 1 single-record mode); write only while idle.
// Reset (rst_n low, synchronous) clears the parse state, the queue and the
// output register and returns the delimiter to comma.
`timescale 1ns / 1ps

module csv_record_tokenizer_top
  import csvt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_final_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_content,
  output logic [7:0]            out_content_byte,
  output logic                  out_field_end,
  output logic                  out_record_end,
  output logic [2:0]            out_error_code,
  output logic                  out_text_done
);

  logic    in_accept;
  logic    push, pop, empty, full;
  entry_t  push_entry, head;
  result_t out_result;

  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  csvt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .push          (push),
    .push_entry    (push_entry)
  );

  csvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_has_content  = out_result.has_content;
  assign out_content_byte = out_result.content_byte;
  assign out_field_end    = out_result.field_end;
  assign out_record_end   = out_result.record_end;
  assign out_error_code   = out_result.error_code;
  assign out_text_done    = out_result.text_done;

endmodule

FILE: rtl/csvt_checker.sv
// Port-level checks for the CSV record tokenizer, bound to the top level.
`timescale 1ns / 1ps

module csvt_checker
  import csvt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_has_content,
  input logic [7:0] out_content_byte,
  input logic       out_field_end,
  input logic       out_record_end,
  input logic [2:0] out_error_code,
  input logic       out_text_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_content_byte) &&
      $stable(out_error_code) && $stable(out_text_done))
    else $error("stalled output transaction changed");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |->
      !out_has_content && !out_field_end && !out_record_end)
    else $error("error result carries content or marks");

  a_record_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_end |-> out_field_end)
    else $error("record end without field end");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind csv_record_tokenizer_top csvt_checker u_csvt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_has_content  (out_has_content),
  .out_content_byte (out_content_byte),
  .out_field_end    (out_field_end),
  .out_record_end   (out_record_end),
  .out_error_code   (out_error_code),
  .out_text_done    (out_text_done)
);
